[rtl/dpb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared widths, register map, mode codes and stage-enable bundle for the
// depth pixel back-projection block.
// ----------------------------------------------------------------------------
package dpb_pkg;

    localparam int DEPTH_W  = 16;
    localparam int COLOR_W  = 8;
    localparam int RGB_W    = 3 * COLOR_W;
    localparam int SCALE_W  = 24;
    localparam int CENTER_W = 20;
    localparam int INV_W    = 24;
    localparam int MODE_W   = 2;
    localparam int Z_W      = 24;
    localparam int POS_W    = 32;
    localparam int PROD_W   = DEPTH_W + SCALE_W;
    localparam int ZFULL_W  = PROD_W - 8;
    localparam int OUT_W    = 2 * POS_W + Z_W + RGB_W;

    // Q.24 to Q.16 rounding of z
    localparam logic [PROD_W-1:0] Z_ROUND = PROD_W'(128);

    // APB
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_DEPTH_SCALE = 3'd0,
        REG_MAX_DEPTH   = 3'd1,
        REG_CENTER_X    = 3'd2,
        REG_CENTER_Y    = 3'd3,
        REG_INV_FOCAL_X = 3'd4,
        REG_INV_FOCAL_Y = 3'd5,
        REG_MODE        = 3'd6,
        REG_KEY_COLOR   = 3'd7
    } reg_idx_t;

    localparam logic [MODE_W-1:0] MODE_KEEP_ALL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DROP_BLACK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KEY_ONLY   = 2'd2;

    localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE = 24'd16777;
    localparam logic [Z_W-1:0]      RST_MAX_DEPTH   = 24'd131072;
    localparam logic [CENTER_W-1:0] RST_CENTER_X    = 20'd84193;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y    = 20'd62107;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_X = 24'd27894;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y = 24'd27906;
    localparam logic [MODE_W-1:0]   RST_MODE        = MODE_DROP_BLACK;
    localparam logic [RGB_W-1:0]    RST_KEY_COLOR   = 24'd8405120;

    // load enables for the three projection stages
    typedef struct packed {
        logic ld_mul;
        logic ld_part;
        logic ld_sum;
    } proj_en_t;

endpackage
`default_nettype wire

[rtl/dpb_project.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_project
// One axis of the back-projection: |d| * z * inv_focal over three register
// stages, rounded half away from zero to Q.16 and saturated to 32 bits.
// ----------------------------------------------------------------------------
module dpb_project
    import dpb_pkg::*;
#(
    parameter int MAG_W = 20
)
(
    input  wire logic                    clk,
    input  wire proj_en_t                en,
    input  wire logic [MAG_W-1:0]        mag,
    input  wire logic                    neg,
    input  wire logic [Z_W-1:0]          z,
    input  wire logic [INV_W-1:0]        inv,
    output logic signed [POS_W-1:0]      pos
);

    localparam int M_W    = MAG_W + Z_W;
    localparam int SPLIT  = INV_W;
    localparam int HI_W   = M_W - SPLIT;
    localparam int LO_PW  = SPLIT + INV_W;
    localparam int HI_PW  = HI_W + INV_W;
    localparam int SUM_W  = M_W + INV_W + 1;
    localparam int Q_W    = SUM_W - 32;

    localparam logic [SUM_W-1:0] HALF_LSB = SUM_W'(64'h8000_0000);
    localparam logic [Q_W-1:0]   NEG_LIM  = Q_W'(64'h8000_0000);
    localparam logic [Q_W-1:0]   POS_LIM  = Q_W'(64'h7FFF_FFFF);

    logic [M_W-1:0]   m_reg;
    logic             neg_a_reg;
    logic [LO_PW-1:0] lo_reg;
    logic [HI_PW-1:0] hi_reg;
    logic             neg_b_reg;
    logic [POS_W-1:0] pos_reg;

    logic [SUM_W-1:0] total;
    logic [Q_W-1:0]   q;
    logic [POS_W-1:0] pos_next;

    always_ff @(posedge clk)
    begin
        if (en.ld_mul)
        begin
            m_reg     <= M_W'(mag) * M_W'(z);
            neg_a_reg <= neg;
        end
        if (en.ld_part)
        begin
            lo_reg    <= LO_PW'(m_reg[SPLIT-1:0]) * LO_PW'(inv);
            hi_reg    <= HI_PW'(m_reg[M_W-1:SPLIT]) * HI_PW'(inv);
            neg_b_reg <= neg_a_reg;
        end
        if (en.ld_sum)
        begin
            pos_reg <= pos_next;
        end
    end

    always_comb
    begin
        total = (SUM_W'(hi_reg) << SPLIT) + SUM_W'(lo_reg) + HALF_LSB;
        q     = total[SUM_W-1:32];
        if (neg_b_reg)
        begin
            if (q > NEG_LIM)
                pos_next = 32'h8000_0000;
            else
                pos_next = 32'd0 - q[POS_W-1:0];
        end
        else
        begin
            if (q > POS_LIM)
                pos_next = 32'h7FFF_FFFF;
            else
                pos_next = q[POS_W-1:0];
        end
    end

    assign pos = pos_reg;

endmodule
`default_nettype wire

[rtl/depth_pixel_backprojection.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// Pinhole back-projection of depth pixels to coloured 3-D points.
// ----------------------------------------------------------------------------
// One pixel beat is taken per clock while s_tready is high, and a kept pixel
// leaves after stage 5; pixels dropped for depth or colour give no output beat.
// The five stages are set by the multiplier chain: depth times scale, the
// z rounding and range check, offset times z, the two partial products of a
// 24-bit split against the reciprocal focal length, and the final rounding
// add with saturation. Each stage holds its beat while the stage after it is
// full and stalled, so the input stalls only when all stages hold a beat and
// the output is not taken. Registers are written through the APB port at byte
// address 4*index and should be changed only while no pixel is in flight.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection
    import dpb_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic      [DATA_W-1:0]     prdata,
    output logic                       pready,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // col, row, depth_raw, red, green, blue (lowest first), zero padded
    input  wire logic [((2*COORD_BITS+DEPTH_W+RGB_W+7)/8)*8-1:0] s_tdata,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // pos_x, pos_y, pos_z, out_red, out_green, out_blue (lowest first)
    output logic      [OUT_W-1:0]      m_tdata
);

    localparam int CB    = COORD_BITS;
    localparam int MAG_W = (CB + 8 > CENTER_W) ? CB + 8 : CENTER_W;

    // ---------------------------------------------------------------- config
    logic [SCALE_W-1:0]  depth_scale_reg;
    logic [Z_W-1:0]      max_depth_reg;
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [INV_W-1:0]    inv_focal_x_reg;
    logic [INV_W-1:0]    inv_focal_y_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [RGB_W-1:0]    key_color_reg;

    reg_idx_t reg_idx;
    logic     cfg_wr;

    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_scale_reg <= RST_DEPTH_SCALE;
            max_depth_reg   <= RST_MAX_DEPTH;
            center_x_reg    <= RST_CENTER_X;
            center_y_reg    <= RST_CENTER_Y;
            inv_focal_x_reg <= RST_INV_FOCAL_X;
            inv_focal_y_reg <= RST_INV_FOCAL_Y;
            mode_reg        <= RST_MODE;
            key_color_reg   <= RST_KEY_COLOR;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_DEPTH_SCALE: depth_scale_reg <= pwdata[SCALE_W-1:0];
                REG_MAX_DEPTH:   max_depth_reg   <= pwdata[Z_W-1:0];
                REG_CENTER_X:    center_x_reg    <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y:    center_y_reg    <= pwdata[CENTER_W-1:0];
                REG_INV_FOCAL_X: inv_focal_x_reg <= pwdata[INV_W-1:0];
                REG_INV_FOCAL_Y: inv_focal_y_reg <= pwdata[INV_W-1:0];
                REG_MODE:        mode_reg        <= pwdata[MODE_W-1:0];
                REG_KEY_COLOR:   key_color_reg   <= pwdata[RGB_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DEPTH_SCALE: prdata = DATA_W'(depth_scale_reg);
            REG_MAX_DEPTH:   prdata = DATA_W'(max_depth_reg);
            REG_CENTER_X:    prdata = DATA_W'(center_x_reg);
            REG_CENTER_Y:    prdata = DATA_W'(center_y_reg);
            REG_INV_FOCAL_X: prdata = DATA_W'(inv_focal_x_reg);
            REG_INV_FOCAL_Y: prdata = DATA_W'(inv_focal_y_reg);
            REG_MODE:        prdata = DATA_W'(mode_reg);
            REG_KEY_COLOR:   prdata = DATA_W'(key_color_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------- stage handshake
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic keep2;

    assign rdy5 = !v5_reg || m_tready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_tready = rdy1;
    assign m_tvalid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg && keep2;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // ---------------------------------------------------------- stage 1
    logic [CB-1:0]      col;
    logic [CB-1:0]      row;
    logic [DEPTH_W-1:0] depth_raw;
    logic [RGB_W-1:0]   rgb_in;

    assign col       = s_tdata[CB-1:0];
    assign row       = s_tdata[2*CB-1:CB];
    assign depth_raw = s_tdata[2*CB+DEPTH_W-1:2*CB];
    // packed red, green, blue with red on top, as the key is held
    assign rgb_in    = {s_tdata[2*CB+DEPTH_W+7:2*CB+DEPTH_W],
                        s_tdata[2*CB+DEPTH_W+15:2*CB+DEPTH_W+8],
                        s_tdata[2*CB+DEPTH_W+23:2*CB+DEPTH_W+16]};

    logic [MAG_W-1:0] px_ext, py_ext, cx_ext, cy_ext;
    logic [MAG_W-1:0] mag_x_next, mag_y_next;
    logic             neg_x_next, neg_y_next;
    logic             keep_col_next;

    always_comb
    begin
        px_ext     = MAG_W'({col, 8'h00});
        py_ext     = MAG_W'({row, 8'h00});
        cx_ext     = MAG_W'(center_x_reg);
        cy_ext     = MAG_W'(center_y_reg);
        neg_x_next = cx_ext > px_ext;
        neg_y_next = cy_ext > py_ext;
        mag_x_next = neg_x_next ? cx_ext - px_ext : px_ext - cx_ext;
        mag_y_next = neg_y_next ? cy_ext - py_ext : py_ext - cy_ext;

        keep_col_next = 1'b1;
        if (mode_reg == MODE_DROP_BLACK && rgb_in == '0)
            keep_col_next = 1'b0;
        if (mode_reg == MODE_KEY_ONLY && rgb_in != key_color_reg)
            keep_col_next = 1'b0;
    end

    logic [PROD_W-1:0] prod1_reg;
    logic [MAG_W-1:0]  mag_x1_reg, mag_y1_reg;
    logic              neg_x1_reg, neg_y1_reg;
    logic              keep1_reg;
    logic [RGB_W-1:0]  rgb1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            prod1_reg  <= PROD_W'(depth_raw) * PROD_W'(depth_scale_reg);
            mag_x1_reg <= mag_x_next;
            mag_y1_reg <= mag_y_next;
            neg_x1_reg <= neg_x_next;
            neg_y1_reg <= neg_y_next;
            keep1_reg  <= keep_col_next;
            rgb1_reg   <= rgb_in;
        end
    end

    // ---------------------------------------------------------- stage 2
    logic [PROD_W-1:0]  z_sum;
    logic [ZFULL_W-1:0] z_full;

    always_comb
    begin
        z_sum  = prod1_reg + Z_ROUND;
        z_full = z_sum[PROD_W-1:8];
        keep2  = keep1_reg && (z_full != '0) && (z_full <= ZFULL_W'(max_depth_reg));
    end

    logic [Z_W-1:0]   z2_reg;
    logic [MAG_W-1:0] mag_x2_reg, mag_y2_reg;
    logic             neg_x2_reg, neg_y2_reg;
    logic [RGB_W-1:0] rgb2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            z2_reg     <= z_full[Z_W-1:0];
            mag_x2_reg <= mag_x1_reg;
            mag_y2_reg <= mag_y1_reg;
            neg_x2_reg <= neg_x1_reg;
            neg_y2_reg <= neg_y1_reg;
            rgb2_reg   <= rgb1_reg;
        end
    end

    // ------------------------------------------------------ stages 3 to 5
    proj_en_t proj_en;

    assign proj_en.ld_mul  = rdy3;
    assign proj_en.ld_part = rdy4;
    assign proj_en.ld_sum  = rdy5;

    logic signed [POS_W-1:0] pos_x, pos_y;

    dpb_project #(.MAG_W(MAG_W)) u_proj_x (
        .clk (clk),
        .en  (proj_en),
        .mag (mag_x2_reg),
        .neg (neg_x2_reg),
        .z   (z2_reg),
        .inv (inv_focal_x_reg),
        .pos (pos_x)
    );

    dpb_project #(.MAG_W(MAG_W)) u_proj_y (
        .clk (clk),
        .en  (proj_en),
        .mag (mag_y2_reg),
        .neg (neg_y2_reg),
        .z   (z2_reg),
        .inv (inv_focal_y_reg),
        .pos (pos_y)
    );

    logic [Z_W-1:0]   z3_reg, z4_reg, z5_reg;
    logic [RGB_W-1:0] rgb3_reg, rgb4_reg, rgb5_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            z3_reg   <= z2_reg;
            rgb3_reg <= rgb2_reg;
        end
        if (rdy4)
        begin
            z4_reg   <= z3_reg;
            rgb4_reg <= rgb3_reg;
        end
        if (rdy5)
        begin
            z5_reg   <= z4_reg;
            rgb5_reg <= rgb4_reg;
        end
    end

    assign m_tdata = {rgb5_reg[7:0], rgb5_reg[15:8], rgb5_reg[23:16],
                      z5_reg, pos_y, pos_x};

endmodule
`default_nettype wire

[rtl/dpb_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_checker
// Port-level checks for the back-projection block, bound to the top level.
// ----------------------------------------------------------------------------
module dpb_checker
    import dpb_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // every point carries a nonzero depth
    a_z_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2*POS_W+Z_W-1:2*POS_W] != '0)
        else $error("output beat with zero depth");

    // the sink taking beats never backs up the source
    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output ready");

    // input stalls only behind a held output beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting output beat");

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
